// ----- rtl/rfa_pkg.sv -----
// rfa_pkg: shared constants and types for the rational fraction adder
// no dependencies

package rfa_pkg;

    localparam int NUM_W  = 16;
    localparam int DEN_W  = 15;
    localparam int SNUM_W = 32;
    localparam int SDEN_W = 30;
    // shared divider operand width, covers lcm and the scaled sum magnitude
    localparam int DIV_W  = 32;
    localparam int CNT_W  = 6;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_ZERODEN = 1'b1;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIV_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quotient;
        logic [DIV_W-1:0]  remainder;
    } div_rsp_t;

endpackage

// ----- rtl/rfa_if.sv -----
// rfa_if: valid/ready channel interfaces for the rational fraction adder
// depends on rfa_pkg

interface rfa_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [rfa_pkg::NUM_W-1:0] first_num;
    logic        [rfa_pkg::DEN_W-1:0] first_den;
    logic signed [rfa_pkg::NUM_W-1:0] second_num;
    logic        [rfa_pkg::DEN_W-1:0] second_den;

    modport source (output valid, first_num, first_den, second_num, second_den,
                    input ready);
    modport sink   (input valid, first_num, first_den, second_num, second_den,
                    output ready);
endinterface

interface rfa_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [rfa_pkg::SNUM_W-1:0] sum_num;
    logic        [rfa_pkg::SDEN_W-1:0] sum_den;
    logic                              status;

    modport source (output valid, sum_num, sum_den, status, input ready);
    modport sink   (input valid, sum_num, sum_den, status, output ready);
endinterface

// ----- rtl/rfa_div.sv -----
// rfa_div: shared restoring divider, one quotient bit per cycle
// depends on rfa_pkg

module rfa_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rfa_pkg::div_req_t req,
    output rfa_pkg::div_rsp_t rsp
);

    logic [rfa_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [rfa_pkg::DIV_W-1:0] rem_reg, rem_next;
    logic [rfa_pkg::DIV_W-1:0] dsr_reg, dsr_next;
    logic [rfa_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [rfa_pkg::DIV_W:0]   trial;
    logic [rfa_pkg::DIV_W:0]   shifted;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[rfa_pkg::DIV_W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[rfa_pkg::DIV_W])
            begin
                rem_next = shifted[rfa_pkg::DIV_W-1:0];
                quo_next = {quo_reg[rfa_pkg::DIV_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[rfa_pkg::DIV_W-1:0];
                quo_next = {quo_reg[rfa_pkg::DIV_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == rfa_pkg::CNT_W'(rfa_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("divider done held");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("divider done without work");
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg && !req.start |=> !busy_reg) else $error("divider woke unasked");

endmodule

// ----- rtl/rational_fraction_adder.sv -----
// rational_fraction_adder: top level, sequencer around one shared divider
// sequencing: five fixed divisions plus one per gcd step; a zero sum takes three fixed
// divisions plus the first gcd's steps; a zero den goes from idle straight to ST_OUT
// throughput: one transaction at a time, in_ch.ready high only in idle
// reset: rst_n asynchronous active low, returns the sequencer to idle
// depends on rfa_pkg, rfa_if, rfa_div

module rational_fraction_adder (
    input  logic           clk,
    input  logic           rst_n,
    rfa_in_if.sink         in_ch,
    rfa_out_if.source      out_ch
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_G1   = 10'b0000000010, // gcd of denominators
        ST_L1   = 10'b0000000100, // d1 / g
        ST_M1   = 10'b0000001000, // lcm = q * d2
        ST_S1   = 10'b0000010000, // lcm / d1
        ST_S2   = 10'b0000100000, // lcm / d2, then products
        ST_SUM  = 10'b0001000000,
        ST_G2   = 10'b0010000000, // gcd of |sum| and lcm
        ST_R1   = 10'b0100000000, // |sum| / g and lcm / g
        ST_OUT  = 10'b1000000000
    } state_t;

    localparam int W = rfa_pkg::DIV_W;

    state_t state_reg, state_next;
    logic              wait_reg, wait_next;   // divider request in flight
    logic              sub_reg, sub_next;     // second division of reduce step
    logic signed [rfa_pkg::NUM_W-1:0] n1_reg, n2_reg;
    logic        [rfa_pkg::DEN_W-1:0] d1_reg, d2_reg;
    logic [W-1:0]      x_reg, x_next, y_reg, y_next;
    logic [W-1:0]      lcm_reg, lcm_next;
    logic [W-1:0]      t_reg, t_next;        // scratch factor
    logic signed [W:0] p1_reg, p1_next, p2_reg, p2_next;
    logic              neg_reg, neg_next;
    logic [W-1:0]      mag_reg, mag_next;
    logic signed [rfa_pkg::SNUM_W-1:0] onum_reg, onum_next;
    logic [rfa_pkg::SDEN_W-1:0]        oden_reg, oden_next;
    logic              ost_reg, ost_next;
    logic signed [W+1:0] total;
    rfa_pkg::div_req_t req;
    rfa_pkg::div_rsp_t rsp;
    logic              in_fire;

    rfa_div u_div (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    assign in_fire     = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign total       = {p1_reg[W], p1_reg} + {p2_reg[W], p2_reg};

    always_comb
    begin
        state_next = state_reg;
        wait_next  = wait_reg;
        sub_next   = sub_reg;
        x_next = x_reg; y_next = y_reg; lcm_next = lcm_reg; t_next = t_reg;
        p1_next = p1_reg; p2_next = p2_reg; neg_next = neg_reg; mag_next = mag_reg;
        onum_next = onum_reg; oden_next = oden_reg; ost_next = ost_reg;
        req = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_ch.first_den == '0 || in_ch.second_den == '0)
                    begin
                        onum_next  = '0;
                        oden_next  = '0;
                        ost_next   = rfa_pkg::STATUS_ZERODEN;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        x_next     = W'(in_ch.first_den);
                        y_next     = W'(in_ch.second_den);
                        wait_next  = 1'b0;
                        state_next = ST_G1;
                    end
                end
            end
            ST_G1, ST_G2:
            begin
                if (!wait_reg)
                begin
                    if (y_reg == '0)
                    begin
                        if (state_reg == ST_G1)
                        begin
                            req.start    = 1'b1;
                            req.dividend = W'(d1_reg);
                            req.divisor  = x_reg;
                            wait_next    = 1'b1;
                            state_next   = ST_L1;
                        end
                        else
                        begin
                            t_next       = x_reg;
                            req.start    = 1'b1;
                            req.dividend = mag_reg;
                            req.divisor  = x_reg;
                            wait_next    = 1'b1;
                            sub_next     = 1'b0;
                            state_next   = ST_R1;
                        end
                    end
                    else
                    begin
                        req.start    = 1'b1;
                        req.dividend = x_reg;
                        req.divisor  = y_reg;
                        wait_next    = 1'b1;
                    end
                end
                else if (rsp.done)
                begin
                    x_next    = y_reg;
                    y_next    = rsp.remainder;
                    wait_next = 1'b0;
                end
            end
            ST_L1:
            begin
                if (rsp.done)
                begin
                    t_next     = rsp.quotient;
                    state_next = ST_M1;
                end
            end
            ST_M1:
            begin
                // quotient < 2^15, d2 < 2^15
                lcm_next     = W'(t_reg[rfa_pkg::DEN_W-1:0] * d2_reg);
                req.start    = 1'b1;
                req.dividend = W'(t_reg[rfa_pkg::DEN_W-1:0] * d2_reg);
                req.divisor  = W'(d1_reg);
                state_next   = ST_S1;
            end
            ST_S1:
            begin
                if (rsp.done)
                begin
                    // lcm / d1 equals d2 / g, below 2^15
                    p1_next      = (W+1)'(n1_reg *
                                   $signed({1'b0, rsp.quotient[rfa_pkg::DEN_W-1:0]}));
                    req.start    = 1'b1;
                    req.dividend = lcm_reg;
                    req.divisor  = W'(d2_reg);
                    state_next   = ST_S2;
                end
            end
            ST_S2:
            begin
                if (rsp.done)
                begin
                    p2_next    = (W+1)'(n2_reg *
                                 $signed({1'b0, rsp.quotient[rfa_pkg::DEN_W-1:0]}));
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (total == '0)
                begin
                    onum_next  = '0;
                    oden_next  = rfa_pkg::SDEN_W'(1);
                    ost_next   = rfa_pkg::STATUS_OK;
                    state_next = ST_OUT;
                end
                else
                begin
                    neg_next   = total[W+1];
                    mag_next   = total[W+1] ? W'(-total) : W'(total);
                    x_next     = total[W+1] ? W'(-total) : W'(total);
                    y_next     = lcm_reg;
                    wait_next  = 1'b0;
                    state_next = ST_G2;
                end
            end
            ST_R1:
            begin
                if (rsp.done)
                begin
                    if (!sub_reg)
                    begin
                        onum_next    = neg_reg ? -rfa_pkg::SNUM_W'(rsp.quotient)
                                               : rfa_pkg::SNUM_W'(rsp.quotient);
                        req.start    = 1'b1;
                        req.dividend = lcm_reg;
                        req.divisor  = t_reg;
                        sub_next     = 1'b1;
                    end
                    else
                    begin
                        oden_next  = rfa_pkg::SDEN_W'(rsp.quotient);
                        ost_next   = rfa_pkg::STATUS_OK;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wait_reg  <= 1'b0;
            sub_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            sub_reg   <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            n1_reg <= in_ch.first_num;
            d1_reg <= in_ch.first_den;
            n2_reg <= in_ch.second_num;
            d2_reg <= in_ch.second_den;
        end
        x_reg <= x_next; y_reg <= y_next; lcm_reg <= lcm_next; t_reg <= t_next;
        p1_reg <= p1_next; p2_reg <= p2_next; neg_reg <= neg_next; mag_reg <= mag_next;
        onum_reg <= onum_next; oden_reg <= oden_next; ost_reg <= ost_next;
    end

    assign out_ch.valid   = (state_reg == ST_OUT);
    assign out_ch.sum_num = onum_reg;
    assign out_ch.sum_den = oden_reg;
    assign out_ch.status  = ost_reg;

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status |-> out_ch.sum_num == '0 && out_ch.sum_den == '0)
        else $error("error result not zero");
    a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.status |-> out_ch.sum_den != '0)
        else $error("zero denominator on good result");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.sum_num))
        else $error("result dropped before taken");

endmodule

// ----- tb/rfa_checker.sv -----
// rfa_checker: watches both channels of the rational fraction adder, predicts each sum
// and compares it field by field; depends on rfa_pkg and rfa_if
`timescale 1ns / 1ps

module rfa_checker (
    input  logic        clk,
    input  logic        rst_n,
    rfa_in_if.sink      in_ch,
    rfa_out_if.sink     out_ch,
    output int          fail_count,
    output int          pending
);

    typedef struct {
        logic signed [rfa_pkg::SNUM_W-1:0] num;
        logic        [rfa_pkg::SDEN_W-1:0] den;
        logic                              status;
    } sum_t;

    sum_t sums_due[$];

    function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
        longint unsigned r;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    function automatic sum_t predict_sum(logic signed [rfa_pkg::NUM_W-1:0] n1,
                                         logic [rfa_pkg::DEN_W-1:0] d1,
                                         logic signed [rfa_pkg::NUM_W-1:0] n2,
                                         logic [rfa_pkg::DEN_W-1:0] d2);
        sum_t            s;
        longint unsigned g;
        longint unsigned lcm;
        longint unsigned mag;
        longint          total;
        if (d1 == 0 || d2 == 0)
        begin
            s.num = '0;
            s.den = '0;
            s.status = rfa_pkg::STATUS_ZERODEN;
            return s;
        end
        g = euclid_gcd(d1, d2);
        lcm = (d1 / g) * d2;
        total = longint'(n1) * longint'(lcm / d1) + longint'(n2) * longint'(lcm / d2);
        s.status = rfa_pkg::STATUS_OK;
        if (total == 0)
        begin
            s.num = '0;
            s.den = rfa_pkg::SDEN_W'(1);
            return s;
        end
        mag = (total < 0) ? longint'(-total) : total;
        g = euclid_gcd(mag, lcm);
        total = total / longint'(g);
        lcm = lcm / g;
        s.num = total[rfa_pkg::SNUM_W-1:0];
        s.den = lcm[rfa_pkg::SDEN_W-1:0];
        return s;
    endfunction

    assign pending = sums_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        sum_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            sums_due.delete();
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                sums_due.push_back(predict_sum(in_ch.first_num, in_ch.first_den,
                                               in_ch.second_num, in_ch.second_den));
            if (out_ch.valid && out_ch.ready)
            begin
                if (sums_due.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result %0d/%0d status %0b",
                                 out_ch.sum_num, out_ch.sum_den, out_ch.status);
                end
                else
                begin
                    want = sums_due.pop_front();
                    if (want.num !== out_ch.sum_num || want.den !== out_ch.sum_den
                        || want.status !== out_ch.status)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("expected %0d/%0d status %0b, got %0d/%0d status %0b",
                                     want.num, want.den, want.status, out_ch.sum_num,
                                     out_ch.sum_den, out_ch.status);
                    end
                end
            end
        end
    end
endmodule

// ----- tb/tb_top.sv -----
// tb_top: stimulus and verdict for the rational fraction adder
// depends on rfa_pkg, rfa_if, rational_fraction_adder and rfa_checker
`timescale 1ns / 1ps

module tb_top;

    localparam int RANDOM_ITEMS = 1230;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    bit   quiet_phase;
    bit   hold_sink;

    rfa_in_if  in_ch ();
    rfa_out_if out_ch ();

    rational_fraction_adder u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    rfa_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch.sink),
        .out_ch     (out_ch.sink),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #200ms;
        $display("rational_fraction_adder: mismatch");
        $finish;
    end

    // one transaction, with an optional idle burst first; valid stays high after it
    task automatic send(logic signed [rfa_pkg::NUM_W-1:0] n1, logic [rfa_pkg::DEN_W-1:0] d1,
                        logic signed [rfa_pkg::NUM_W-1:0] n2, logic [rfa_pkg::DEN_W-1:0] d2);
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.first_num  <= n1;
        in_ch.first_den  <= d1;
        in_ch.second_num <= n2;
        in_ch.second_den <= d2;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [rfa_pkg::DEN_W-1:0] pick_den();
        case ($urandom_range(0, 9))
            0:       return rfa_pkg::DEN_W'($urandom_range(1, 4));
            1:       return {rfa_pkg::DEN_W{1'b1}};
            2:       return '0;
            3, 4:    return rfa_pkg::DEN_W'($urandom_range(1, 64));
            default: return rfa_pkg::DEN_W'($urandom_range(1, (1 << rfa_pkg::DEN_W) - 1));
        endcase
    endfunction

    function automatic logic signed [rfa_pkg::NUM_W-1:0] pick_num();
        case ($urandom_range(0, 7))
            0:       return {1'b1, {(rfa_pkg::NUM_W-1){1'b0}}};
            1:       return {1'b0, {(rfa_pkg::NUM_W-1){1'b1}}};
            2:       return rfa_pkg::NUM_W'($urandom_range(0, 8) - 4);
            default: return rfa_pkg::NUM_W'($urandom());
        endcase
    endfunction

    // receiver: random stall bursts, plus one long hold-off
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink)
                out_ch.ready <= 1'b0;
            else if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                out_ch.ready <= 1'b1;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        int a;
        logic signed [rfa_pkg::NUM_W-1:0] n;
        logic [rfa_pkg::DEN_W-1:0] d;
        in_ch.valid      = 1'b0;
        in_ch.first_num  = '0;
        in_ch.first_den  = '0;
        in_ch.second_num = '0;
        in_ch.second_den = '0;
        quiet_phase = 1'b0;
        hold_sink = 1'b0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, zero denominators, zero sum, sign, coprime limits
        send(16'sh7fff, 15'h7fff, 16'sh7fff, 15'h7ffe);
        send(16'sh8000, 15'h7fff, 16'sh8000, 15'h7ffe);
        send(16'sh8000, 15'h7ffe, 16'sh7fff, 15'h7fff);
        send(16'sh0001, 15'h0000, 16'sh0001, 15'h0003);
        send(16'sh0001, 15'h0005, 16'sh0002, 15'h0000);
        send(16'sh0000, 15'h0000, 16'sh0000, 15'h0000);
        send(16'sh0003, 15'h0004, -16'sh0003, 15'h0004);
        send(16'sh0001, 15'h0002, -16'sh0002, 15'h0004);
        send(16'sh0000, 15'h0007, 16'sh0000, 15'h0009);
        send(16'sh0001, 15'h0002, 16'sh0001, 15'h0002);
        send(-16'sh0001, 15'h0003, -16'sh0001, 15'h0006);
        send(16'sh0001, 15'h0001, 16'sh0001, 15'h0001);
        send(16'sh5555, 15'h2aaa, 16'shaaaa, 15'h5555);
        send(16'sh0006, 15'h0004, 16'sh0002, 15'h0004);
        send(16'sh7fff, 15'h0001, 16'sh7fff, 15'h0001);
        send(16'sh8000, 15'h0001, 16'sh8000, 15'h0001);
        send(16'sh0002, 15'h7fff, 16'sh0003, 15'h7fff);
        send(16'sh1234, 15'h4000, 16'sh0001, 15'h4000);
        in_ch.valid <= 1'b0;

        // sender pauses until every expected result is back
        while (pending != 0)
            @(negedge clk);

        // long receiver hold-off while items keep coming
        hold_sink = 1'b1;
        fork
            begin
                repeat (6000) @(negedge clk);
                hold_sink = 1'b0;
            end
            begin
                repeat (6) send(pick_num(), pick_den(), pick_num(), pick_den());
                in_ch.valid <= 1'b0;
            end
        join

        for (a = 0; a < RANDOM_ITEMS; a++)
        begin
            if (a == RANDOM_ITEMS - 150)
                quiet_phase = 1'b1;
            if ($urandom_range(0, 4) == 0)
            begin
                // same denominator, opposite numerators: zero sum unless n is the most negative value
                n = pick_num();
                d = rfa_pkg::DEN_W'($urandom_range(1, (1 << rfa_pkg::DEN_W) - 1));
                send(n, d, -n, d);
            end
            else
                send(pick_num(), pick_den(), pick_num(), pick_den());
        end
        in_ch.valid <= 1'b0;

        a = 0;
        while (pending != 0 && a < 200000)
        begin
            @(negedge clk);
            a++;
        end
        repeat (100) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("rational_fraction_adder: match");
        else
            $display("rational_fraction_adder: mismatch");
        $finish;
    end
endmodule

// ----- rational_fraction_adder.f -----
rtl/rfa_pkg.sv
rtl/rfa_if.sv
rtl/rfa_div.sv
rtl/rational_fraction_adder.sv
tb/rfa_checker.sv
tb/tb_top.sv
